// ===== src/msv_pkg.sv =====
// Shared types and constants for the monotonic stack visibility block.
// No dependencies; every other file in src imports this package.
package msv_pkg;

    localparam int HEIGHT_W      = 32;
    localparam int COUNT_W       = 7;
    localparam int COUNT_MAX     = 127;
    localparam int DEPTH_DEFAULT = 64;

    // Status that one cell hands to its upper neighbor and to the top level.
    typedef struct packed {
        logic keep;   // entry is valid and taller than the incoming height
        logic valid;  // entry holds a pushed height
    } msv_cell_stat_t;

endpackage

// ===== src/msv_cell.sv =====
// One stack slot of the monotonic stack: a valid flag and a stored height.
// Depends on msv_pkg for the height width and the status struct.
module msv_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 update,
    input  logic signed [msv_pkg::HEIGHT_W-1:0]  height,
    input  logic                                 below_keep,
    output msv_pkg::msv_cell_stat_t              stat
);
    import msv_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [HEIGHT_W-1:0] height_reg;
    logic signed [HEIGHT_W-1:0] height_next;
    logic                       keep;
    logic                       push_here;

    // The stack is strictly decreasing upward, so the entries that survive
    // form a prefix, and the new height lands in the first slot past it.
    assign keep      = valid_reg && (height_reg > height);
    assign push_here = below_keep && !keep;

    always_comb begin
        valid_next  = valid_reg;
        height_next = height_reg;
        if (update) begin
            if (push_here) begin
                valid_next  = 1'b1;
                height_next = height;
            end else if (!keep) begin
                valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        height_reg <= height_next;
    end

    assign stat.keep  = keep;
    assign stat.valid = valid_reg;

endmodule

// ===== src/monotonic_stack_visibility.sv =====
// Top level of the monotonic stack visibility block: a row of stack cells,
// the depth counter and the result register. Depends on msv_pkg and msv_cell.
//
//   Channel  Ports                               Word
//   input    s_valid, s_ready, s_height          one signed 32-bit height
//   result   m_valid, m_ready, m_visible_count   stack depth before the height
//
// Every accepted word is resolved in the cycle it is accepted: all cells
// compare against the new height in parallel, so one word per cycle flows
// through unless stalled. The result is registered at acceptance. Reset
// (aresetn low at a rising edge) clears the cell valid flags and the depth.
// A stalled result holds the input side, since s_ready follows the output
// register being empty or being drained in the same cycle.
module monotonic_stack_visibility #(
    parameter int DEPTH = msv_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [msv_pkg::HEIGHT_W-1:0]  s_height,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [msv_pkg::COUNT_W-1:0]   m_visible_count
);
    import msv_pkg::*;

    localparam int DW = $clog2(DEPTH + 1);

    msv_cell_stat_t       stat [DEPTH];
    logic [DEPTH-1:0]     keep_vec;
    logic [DEPTH-1:0]     valid_vec;
    logic [DEPTH-1:0]     boundary;
    logic                 accept;
    logic [DW-1:0]        depth_reg;
    logic [DW-1:0]        depth_next;
    logic [DW-1:0]        depth_after;
    logic [COUNT_W-1:0]   count_sat;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [COUNT_W-1:0]   m_count_reg;
    logic [COUNT_W-1:0]   m_count_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // The row of cells. Each cell sees whether the cell below it keeps its
    // entry; the bottom cell treats the floor as a kept entry.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_bottom
            msv_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .update     (accept),
                .height     (s_height),
                .below_keep (1'b1),
                .stat       (stat[i])
            );
            assign boundary[i] = !stat[i].keep;
        end else begin : g_upper
            msv_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .update     (accept),
                .height     (s_height),
                .below_keep (stat[i-1].keep),
                .stat       (stat[i])
            );
            assign boundary[i] = stat[i-1].keep && !stat[i].keep;
        end
        assign keep_vec[i]  = stat[i].keep;
        assign valid_vec[i] = stat[i].valid;
    end

    // The kept entries form a prefix, so at most one boundary bit is set. Its
    // position plus one is the new depth. With no boundary every slot is kept,
    // which means the stack was full and the push is dropped.
    always_comb begin
        depth_after = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (boundary[i]) begin
                depth_after = depth_after | DW'(i + 1);
            end
        end
        if (boundary == '0) begin
            depth_after = DW'(DEPTH);
        end
    end

    // The depth before the word is reported, saturated to the field width.
    if (DW > COUNT_W) begin : g_sat
        assign count_sat = (depth_reg > DW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                        : depth_reg[COUNT_W-1:0];
    end else begin : g_nosat
        assign count_sat = COUNT_W'(depth_reg);
    end

    always_comb begin
        depth_next   = depth_reg;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            depth_next   = depth_after;
            m_valid_next = 1'b1;
            m_count_next = count_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_count_reg <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_visible_count = m_count_reg;

    // The depth counter must match the number of occupied cells.
    a_depth_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(depth_reg))
        else $error("depth counter disagrees with occupied cells");

    // Surviving entries always form a prefix of the row.
    a_keep_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(boundary) <= 1 && ((keep_vec & ~valid_vec) == '0))
        else $error("kept entries do not form a prefix");

    // An accepted word always leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word produced no result");

    // The depth never exceeds the capacity.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(depth_reg) <= DEPTH)
        else $error("stack depth beyond capacity");

endmodule

// ===== sim/monotonic_stack_visibility_tb.sv =====
// Testbench for monotonic_stack_visibility: random and corner-case heights are checked
// word by word against a behavioral stack predictor kept in the bench.
// Depends on msv_pkg and the block's sources in src.
`timescale 1ns / 1ps

module monotonic_stack_visibility_tb;
    import msv_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEFAULT;
    localparam int ITEM_TARGET = 750;

    // One pending input word. When wait_drain is set, the driver holds the word
    // back until every result already in flight has been received.
    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        bit                         wait_drain;
    } tower_word_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [HEIGHT_W-1:0]  s_height = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic        [COUNT_W-1:0]   m_visible_count;

    tower_word_t                 pending_heights[$];
    logic        [COUNT_W-1:0]   expected_counts[$];

    // Bench copy of the stack. Only entries below tower_depth are meaningful.
    logic signed [HEIGHT_W-1:0]  tower_stack [STACK_DEPTH];
    int unsigned                 tower_depth = 0;

    int                          error_count = 0;
    int                          words_sent = 0;
    int                          words_seen = 0;
    int                          send_gap = 0;
    int                          recv_stall = 0;
    bit                          send_steady = 1'b0;
    bit                          recv_steady = 1'b0;

    // Heights that hit the ends of the signed range, equal neighbors and
    // alternating bit patterns.
    logic signed [HEIGHT_W-1:0]  corner_heights [20] = '{
        32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0003, 32'h0000_0004, 32'hAAAA_AAAA,
        32'h5555_5555, 32'h8000_0001, 32'h8000_0000, 32'h0000_0000,
        32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE
    };

    monotonic_stack_visibility #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_height(s_height),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_visible_count(m_visible_count)
    );

    always #6 aclk = ~aclk;

    // Applies one height to the bench stack and returns the visible count the
    // block must report for it: the depth before the word, saturated to the
    // field. Entries at or below the new height are popped, and the push is
    // dropped when the stack is still full afterwards.
    function automatic logic [COUNT_W-1:0] predict_visible(input logic signed [HEIGHT_W-1:0] h);
        int unsigned seen;
        seen = tower_depth;
        while (tower_depth > 0 && tower_stack[tower_depth - 1] <= h) begin
            tower_depth--;
        end
        if (tower_depth < STACK_DEPTH) begin
            tower_stack[tower_depth] = h;
            tower_depth++;
        end
        return (seen > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(seen);
    endfunction

    // Draws the wait before the next word on one side. Each side now and then
    // flips into a steady stretch with no idling at all, and back out again.
    function automatic int draw_wait(inout bit steady);
        if ($urandom_range(0, 29) == 0) begin
            steady = !steady;
        end
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH result %0d at %0t: %s, got %0d, want %0d",
                 words_seen, $realtime, what, got, want);
    endtask

    task automatic add_height(input longint h, input bit wait_drain);
        tower_word_t word;
        word.height = h[HEIGHT_W-1:0];
        word.wait_drain = wait_drain;
        pending_heights.push_back(word);
    endtask

    // Queues one run of heights. Most runs are monotonic with random start and
    // step, since only long descending runs grow the stack to its full depth;
    // the rest are narrow-range values that collide often and raw noise.
    task automatic queue_segment(input int kind, input bit hold_first);
        int     len;
        int     max_step;
        int     min_step;
        longint h;
        longint limit;
        case (kind) inside
            [0:4]: begin
                if ($urandom_range(0, 3) == 0) begin
                    len = $urandom_range(64, 72);
                    min_step = 1;
                end else begin
                    len = $urandom_range(1, 20);
                    min_step = ($urandom_range(0, 4) == 0) ? 0 : 1;
                end
                case ($urandom_range(0, 3))
                    0: max_step = 1;
                    1: max_step = 4;
                    2: max_step = 1000;
                    default: max_step = 1 << 24;
                endcase
                h = longint'($signed($urandom));
                limit = -64'sd2147483648 + longint'(len) * max_step;
                if (h < limit) begin
                    h = limit;
                end
                for (int i = 0; i < len; i++) begin
                    add_height(h, hold_first && i == 0);
                    h = h - $urandom_range(min_step, max_step);
                end
            end
            [5:6]: begin
                len = $urandom_range(1, 10);
                max_step = ($urandom_range(0, 1) == 0) ? 3 : (1 << 20);
                h = longint'($signed($urandom));
                limit = 64'sd2147483647 - longint'(len) * max_step;
                if (h > limit) begin
                    h = limit;
                end
                for (int i = 0; i < len; i++) begin
                    add_height(h, hold_first && i == 0);
                    h = h + $urandom_range(0, max_step);
                end
            end
            7: begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    add_height(longint'($urandom_range(0, 6)) - 3, hold_first && i == 0);
                end
            end
            default: begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    add_height(longint'($signed($urandom)), hold_first && i == 0);
                end
            end
        endcase
    endtask

    // Driver. The expectation for a word is computed when the word is put on
    // the bus: words are accepted strictly in that order, and the result can
    // only come after acceptance, so the monitor never finds it missing.
    always @(posedge aclk) begin
        tower_word_t word;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = draw_wait(send_steady);
        end else if (s_valid && !s_ready) begin
            // The word stays on the bus, unchanged, until it is taken.
        end else begin
            if (s_valid) begin
                words_sent++;
            end
            if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_heights.size() != 0 &&
                         !(pending_heights[0].wait_drain && expected_counts.size() != 0)) begin
                word = pending_heights.pop_front();
                expected_counts.push_back(predict_visible(word.height));
                s_valid <= 1'b1;
                s_height <= word.height;
                send_gap = draw_wait(send_steady);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor. After each received word the ready line may drop for a random
    // wait, so stalls land both while results are waiting and while the output
    // is empty.
    always @(posedge aclk) begin
        logic [COUNT_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = draw_wait(recv_steady);
        end else if (m_valid && m_ready) begin
            words_seen++;
            if (expected_counts.size() == 0) begin
                report_mismatch("result with none expected", m_visible_count, 0);
            end else begin
                want = expected_counts.pop_front();
                if (m_visible_count !== want) begin
                    report_mismatch("visible_count", m_visible_count, want);
                end
            end
            recv_stall = draw_wait(recv_steady);
            m_ready <= (recv_stall == 0);
        end else if (recv_stall != 0) begin
            recv_stall--;
            m_ready <= (recv_stall == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        // Corner words first, then one long descending run that fills the
        // stack, held back until the corner results have all come back.
        foreach (corner_heights[i]) begin
            add_height(longint'(corner_heights[i]), 1'b0);
        end
        for (int i = 0; i < STACK_DEPTH + 6; i++) begin
            add_height(longint'(1000 - i), i == 0);
        end
        while (pending_heights.size() < ITEM_TARGET) begin
            queue_segment($urandom_range(0, 9), $urandom_range(0, 15) == 0);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_heights.size() != 0 || expected_counts.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        // The block registers each result at acceptance; the extra wait below
        // catches any stray result.
        repeat (20) @(posedge aclk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/msv_pkg.sv
src/msv_cell.sv
src/monotonic_stack_visibility.sv
sim/monotonic_stack_visibility_tb.sv
